// ===== rtl/core/atlp_pkg.sv =====
// ----------------------------------------------------------------------------
// atlp_pkg
// Shared types, widths and lane-group helpers for the traffic light phaser.
// ----------------------------------------------------------------------------
package atlp_pkg;

   localparam int TS_W        = 31;  // timestamp width
   localparam int OCC_W       = 8;   // one detector bit per lane
   localparam int STEPS_W     = 16;  // steps_green register width
   localparam int SINCE_W     = 32;  // green_since, two's complement
   localparam int ELAPSED_W   = SINCE_W + 1;
   localparam int GROUP_W     = 2;
   localparam int NUM_GROUPS  = 4;
   localparam int CNT_W       = $clog2(TS_W + 1);
   localparam int CSR_DATA_W  = STEPS_W;

   localparam logic [STEPS_W-1:0] STEPS_GREEN_RESET = 16'd10;

   // register indexes on the configuration port
   localparam logic CSR_STEPS_GREEN = 1'b0;
   localparam logic CSR_MODE        = 1'b1;

   typedef enum logic [1:0] {
      MODE_FIXED_PAIRED,
      MODE_FIXED_OPPOSITE,
      MODE_ACT_PAIRED,
      MODE_ACT_OPPOSITE
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_ELAPSED,
      ST_DECIDE,
      ST_DONE
   } state_type;

   // sequencer to actuated phase unit
   typedef struct packed {
      logic calc_en;    // register timestamp - green_since
      logic decide_en;  // compare, pick group, update state
      logic opposite;   // lane layout
   } phase_ctrl_type;

   // lanes of group g: paired is 2g and 2g+1, opposite is g and g+4
   function automatic logic [OCC_W-1:0] group_mask(input logic [GROUP_W-1:0] g,
                                                   input logic opposite);
      logic [OCC_W-1:0] m;
      if (opposite) begin
         m = (OCC_W'(1) << g) | (OCC_W'(1) << (OCC_W'(g) + OCC_W'(NUM_GROUPS)));
      end else begin
         m = OCC_W'(3) << {g, 1'b0};
      end
      return m;
   endfunction

endpackage

// ===== rtl/core/actuated_traffic_light_phaser.sv =====
// Fixed-time modes: the serial divider (one quotient bit per cycle over 31
// timestamp bits) picks the group, then the output register is loaded.
// Actuated modes: elapsed time, group decision, output register, in that order.
// A new request is accepted only once the previous one has been loaded out.
// Reset: synchronous, active high; steps_green 10, mode 0, group 0, since 0.
// ----------------------------------------------------------------------------
// actuated_traffic_light_phaser
// Sequencer, configuration registers and output register of the phaser.
// ----------------------------------------------------------------------------
module actuated_traffic_light_phaser
   import atlp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [TS_W-1:0]        req_timestamp,
   input  logic [OCC_W-1:0]       req_front_occupied,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [OCC_W-1:0]       rsp_green_mask,
   input  logic                   csr_wr_en,
   input  logic                   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wr_data
);

   state_type              state_ff, state_in;
   mode_type               mode_ff;
   logic [STEPS_W-1:0]     steps_ff;
   logic [TS_W-1:0]        ts_ff;
   logic [OCC_W-1:0]       occ_ff;
   logic [OCC_W-1:0]       mask_ff, mask_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [OCC_W-1:0]       rsp_mask_ff;
   logic                   accept;
   logic                   fixed_mode;
   logic                   opposite;
   logic                   out_load;
   logic                   div_done;
   logic [GROUP_W-1:0]     div_quot;
   logic [STEPS_W-1:0]     divisor;
   logic [OCC_W-1:0]       phase_mask;
   phase_ctrl_type         phase_ctrl;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign fixed_mode = (mode_ff == MODE_FIXED_PAIRED) || (mode_ff == MODE_FIXED_OPPOSITE);
   assign opposite   = (mode_ff == MODE_FIXED_OPPOSITE) || (mode_ff == MODE_ACT_OPPOSITE);
   // zero steps divides as one
   assign divisor    = (steps_ff == '0) ? STEPS_W'(1) : steps_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_GREEN_RESET;
         mode_ff  <= MODE_FIXED_PAIRED;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_STEPS_GREEN: steps_ff <= csr_wr_data;
            CSR_MODE:        mode_ff  <= mode_type'(csr_wr_data[1:0]);
            default:         ;
         endcase
      end
   end

   atlp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && fixed_mode),
      .dividend (req_timestamp),
      .divisor  (divisor),
      .done     (div_done),
      .quot_low (div_quot)
   );

   assign phase_ctrl.calc_en   = (state_ff == ST_ELAPSED);
   assign phase_ctrl.decide_en = (state_ff == ST_DECIDE);
   assign phase_ctrl.opposite  = opposite;

   atlp_phase u_phase (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (phase_ctrl),
      .timestamp      (ts_ff),
      .front_occupied (occ_ff),
      .steps_green    (steps_ff),
      .green_mask     (phase_mask)
   );

   always_comb begin
      state_in = state_ff;
      mask_in  = mask_ff;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = fixed_mode ? ST_DIV : ST_ELAPSED;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mask_in  = group_mask(div_quot, opposite);
               state_in = ST_DONE;
            end
         end
         ST_ELAPSED: state_in = ST_DECIDE;
         ST_DECIDE: begin
            mask_in  = phase_mask;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mask_ff <= mask_in;
      if (accept) begin
         ts_ff  <= req_timestamp;
         occ_ff <= req_front_occupied;
      end
      if (out_load) begin
         rsp_mask_ff <= mask_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_green_mask = rsp_mask_ff;

endmodule

// ===== rtl/core/atlp_div.sv =====
// ----------------------------------------------------------------------------
// atlp_div
// Restoring serial divider, one quotient bit per cycle. Only the two least
// significant quotient bits are kept, as the group index is quotient mod 4.
// ----------------------------------------------------------------------------
module atlp_div
   import atlp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [TS_W-1:0]      dividend,
   input  logic [STEPS_W-1:0]   divisor,
   output logic                 done,
   output logic [GROUP_W-1:0]   quot_low
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [TS_W-1:0]      dvd_ff, dvd_in;
   logic [STEPS_W-1:0]   dsr_ff, dsr_in;
   logic [STEPS_W-1:0]   rem_ff, rem_in;
   logic [GROUP_W-1:0]   quot_ff, quot_in;
   logic [STEPS_W:0]     trial;
   logic [STEPS_W:0]     diff;
   logic                 fits;

   // remainder stays below the divisor, so it fits in STEPS_W bits
   assign trial = {rem_ff, dvd_ff[TS_W-1]};
   assign diff  = trial - {1'b0, dsr_ff};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dsr_in  = dsr_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(TS_W);
         dvd_in  = dividend;
         dsr_in  = divisor;
         rem_in  = '0;
         quot_in = '0;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[TS_W-2:0], 1'b0};
         rem_in  = fits ? diff[STEPS_W-1:0] : trial[STEPS_W-1:0];
         quot_in = {quot_ff[0], fits};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quot_low = quot_ff;

endmodule

// ===== rtl/core/atlp_phase.sv =====
// ----------------------------------------------------------------------------
// atlp_phase
// Detector-actuated phase state: current group and the tick it turned green.
// Registers the elapsed time, then decides the next group.
// ----------------------------------------------------------------------------
module atlp_phase
   import atlp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  phase_ctrl_type       ctrl,
   input  logic [TS_W-1:0]      timestamp,
   input  logic [OCC_W-1:0]     front_occupied,
   input  logic [STEPS_W-1:0]   steps_green,
   output logic [OCC_W-1:0]     green_mask
);

   logic [GROUP_W-1:0]    group_ff, group_in;
   logic [SINCE_W-1:0]    since_ff, since_in;
   logic [ELAPSED_W-1:0]  elapsed_ff;
   logic                  expired;

   always_ff @(posedge clock) begin
      if (ctrl.calc_en) begin
         // exact difference, green_since sign extended
         elapsed_ff <= {2'b00, timestamp} - {since_ff[SINCE_W-1], since_ff};
      end
   end

   assign expired = $signed(elapsed_ff) >= $signed({{(ELAPSED_W-STEPS_W){1'b0}}, steps_green});

   always_comb begin
      logic                 found;
      logic [GROUP_W-1:0]   g;
      logic [OCC_W-1:0]     m;
      group_in   = group_ff;
      since_in   = since_ff;
      green_mask = '0;
      found      = 1'b0;
      g          = '0;
      m          = '0;
      if (expired) begin
         // round robin from the group after the current one, itself last
         for (int k = 1; k <= NUM_GROUPS; k++) begin
            g = group_ff + GROUP_W'(k);
            m = group_mask(g, ctrl.opposite);
            if (!found && ((front_occupied & m) != '0)) begin
               found      = 1'b1;
               group_in   = g;
               since_in   = {1'b0, timestamp};
               green_mask = m;
            end
         end
      end else begin
         green_mask = group_mask(group_ff, ctrl.opposite);
         // empty group: its green time counts as expired on the next tick
         if ((front_occupied & green_mask) == '0) begin
            since_in = SINCE_W'(0) - {{(SINCE_W-STEPS_W){1'b0}}, steps_green};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_ff <= '0;
         since_ff <= '0;
      end else if (ctrl.decide_en) begin
         group_ff <= group_in;
         since_ff <= since_in;
      end
   end

endmodule

// ===== rtl/core/atlp_checker.sv =====
// ----------------------------------------------------------------------------
// atlp_checker
// Port-level checks on the traffic light phaser, bound to the top level.
// ----------------------------------------------------------------------------
module atlp_checker
   import atlp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [OCC_W-1:0]   rsp_green_mask
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_green_mask))
      else $error("green mask changed while stalled");

   // one transaction at a time
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // at most one group green
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones(rsp_green_mask) == 2) || (rsp_green_mask == '0))
      else $error("green mask is not a single group");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind actuated_traffic_light_phaser atlp_checker u_atlp_checker (.*);
